// ===== rtl/sis_pkg.sv =====
// Package with the shared types and constants of the sorted insertion store.
`default_nettype none
package sis_pkg;

	localparam int VALUE_W = 16;
	localparam int COUNT_W = 8;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Command broadcast to every cell in the chain for the current word.
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic [VALUE_W-1:0] value;
	} sis_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/sis_cell.sv =====
// One cell of the sorted chain: holds a value and trades it with its neighbors.
`default_nettype none
module sis_cell (
	input  wire                             clk,
	input  wire sis_pkg::sis_cmd_t          cmd,
	input  wire                             occupied,
	input  wire                             is_tail,
	input  wire [sis_pkg::VALUE_W-1:0]      prev_val,
	input  wire                             prev_ge,
	input  wire [sis_pkg::VALUE_W-1:0]      next_val,
	output logic [sis_pkg::VALUE_W-1:0]     cell_val,
	output logic                            ge
);
	import sis_pkg::*;

	logic [VALUE_W-1:0] val_q;

	// The cell holds a value not smaller than the incoming one.
	assign ge       = occupied && (val_q >= cmd.value);
	assign cell_val = val_q;

	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			val_q <= next_val;
		end else if (cmd.ins) begin
			// The left neighbor moves in when it is displaced; the new value
			// lands in the first cell that is not smaller, or at the tail.
			if (prev_ge) begin
				val_q <= prev_val;
			end else if (ge || is_tail) begin
				val_q <= cmd.value;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sorted_insertion_store.sv =====
// Top level of the sorted insertion store: a chain of cells kept in ascending order.
//
// Usage: a request word (mode, value) enters when req_valid is high and req_stall
// is low. Mode insert places the value before the first held value that is not
// smaller; mode remove pops the smallest held value. Every request word gives one
// response word (out_value, out_valid, stored_count, dropped), taken when
// rsp_valid is high and rsp_stall is low.
// The response is registered in the output register, or in the skid register
// while the former is full. One request is taken per cycle while req_stall
// is low; every cell compares its own value with the broadcast value and shifts with
// its neighbor in the same cycle, so the chain, not the fill level, sets the rate.
// A two-word response buffer (output register plus skid register) lets a request
// be taken while a response waits; req_stall rises only when both are full.
// Reset clears the count and the response buffer; cell contents are not reset,
// since only cells below the count are ever read.
`default_nettype none
module sorted_insertion_store #(
	parameter int CAPACITY = 128
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  wire                          mode,
	input  wire [sis_pkg::VALUE_W-1:0]   value,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output logic [sis_pkg::VALUE_W-1:0]  out_value,
	output logic                         out_valid,
	output logic [sis_pkg::COUNT_W-1:0]  stored_count,
	output logic                         dropped
);
	import sis_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic [CW-1:0]      count;
		logic               drop;
	} rsp_t;

	logic [CW-1:0] count_q;
	logic          accept;
	logic          ins_ok;
	logic          rem_ok;
	logic [CW-1:0] count_next;
	sis_cmd_t      cmd;
	rsp_t          rsp_new;
	rsp_t          out_q;
	rsp_t          skid_q;
	logic          out_vld_q;
	logic          skid_vld_q;
	logic          out_take;

	logic [VALUE_W-1:0] vals [CAPACITY];
	logic [CAPACITY-1:0] ges;

	assign accept = req_valid && !req_stall;
	assign ins_ok = accept && (mode == MODE_INSERT) && (count_q != CAP_C);
	assign rem_ok = accept && (mode == MODE_REMOVE) && (count_q != '0);

	assign cmd.ins   = ins_ok;
	assign cmd.rem   = rem_ok;
	assign cmd.value = value;

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + CW'(1);
		end else if (rem_ok) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// The chain of cells; cell 0 always holds the smallest value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic [VALUE_W-1:0] prev_v;
		logic               prev_g;
		logic [VALUE_W-1:0] next_v;

		if (i == 0) begin : g_head
			assign prev_v = value;
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_v = vals[i-1];
			assign prev_g = ges[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_v = vals[i];
		end else begin : g_inner
			assign next_v = vals[i+1];
		end

		sis_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (IDX < count_q),
			.is_tail  (IDX == count_q),
			.prev_val (prev_v),
			.prev_ge  (prev_g),
			.next_val (next_v),
			.cell_val (vals[i]),
			.ge       (ges[i])
		);
	end

	// The response for the word taken this cycle.
	always_comb begin
		rsp_new.value = rem_ok ? vals[0] : '0;
		rsp_new.valid = rem_ok;
		rsp_new.count = count_next;
		rsp_new.drop  = accept && (mode == MODE_INSERT) && (count_q == CAP_C);
	end

	// Output register with a skid register behind it.
	assign out_take  = out_vld_q && !rsp_stall;
	assign req_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_vld_q && !out_take) begin
				skid_vld_q <= 1'b1;
			end
			out_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_vld_q && !out_take) begin
				skid_q <= rsp_new;
			end else begin
				out_q <= rsp_new;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign out_value = out_q.value;
	assign out_valid = out_q.valid;
	assign dropped   = out_q.drop;

	if (CW >= COUNT_W) begin : g_cnt_trunc
		assign stored_count = out_q.count[COUNT_W-1:0];
	end else begin : g_cnt_ext
		assign stored_count = {{(COUNT_W-CW){1'b0}}, out_q.count};
	end

endmodule
`default_nettype wire

// ===== bench/tb_sorted_insertion_store.sv =====
// Self-checking bench for the sorted insertion store: random traffic, own store model.
`default_nettype none
module tb_sorted_insertion_store;
	timeunit 1ns;
	timeprecision 1ps;

	import sis_pkg::*;

	// The store is built at its default size. The bench keeps its own copy of the
	// capacity so that it can predict refused inserts.
	localparam int STORE_DEPTH = 128;

	// This limit only catches a hang.
	localparam int CYCLE_LIMIT = 60000;

	// The output side stops taking words for this many cycles once this many
	// request words have gone in. The input side keeps offering words meanwhile,
	// so the two-word response buffer fills up and req_stall has to rise.
	localparam int HOLD_AFTER_WORDS = 100;
	localparam int HOLD_CYCLES = 400;

	// Between these word counts neither side idles, so the block runs at its
	// full rate of one word per cycle.
	localparam int QUIET_FROM = 300;
	localparam int QUIET_TO = 420;

	// Chance, in percent, that a side idles in a given cycle.
	localparam int IDLE_PCT = 33;

	// One request word waiting to be driven. When wait_drain is set, the driver
	// holds this word back until every response still due has arrived.
	typedef struct packed {
		logic               mode;
		logic [VALUE_W-1:0] value;
		logic               wait_drain;
	} store_req_t;

	// One response word as the block should give it.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic [COUNT_W-1:0] count;
		logic               dropped;
	} store_rsp_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic                mode = MODE_INSERT;
	logic [VALUE_W-1:0]  value = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [VALUE_W-1:0]  out_value;
	logic                out_valid;
	logic [COUNT_W-1:0]  stored_count;
	logic                dropped;

	// Request words that the stimulus has queued but the driver has not yet sent.
	store_req_t          pending_reqs[$];
	// Responses owed by the block, oldest first.
	store_rsp_t          owed_rsps[$];
	// The bench's picture of the store contents, kept in ascending order.
	logic [VALUE_W-1:0]  held_values[$];

	int                  words_in = 0;
	int                  words_out = 0;
	int                  mismatches = 0;
	int                  cycle_cnt = 0;
	int                  hold_left = 0;
	logic                hold_started = 1'b0;
	logic                hold_active;
	logic                send_quiet;
	logic                take_quiet;

	sorted_insertion_store #(
		.CAPACITY(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.out_value(out_value),
		.out_valid(out_valid),
		.stored_count(stored_count),
		.dropped(dropped)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one accepted request word to the bench's own store and records the
	// response that the block owes for it. A remove takes the head of the sorted
	// list; an insert goes in front of the first held value that is not smaller,
	// so it goes before equal values; an insert into a full store is refused.
	task automatic apply_store_word(input logic req_mode, input logic [VALUE_W-1:0] req_value);
		store_rsp_t rsp;
		int         pos;
		rsp = '0;
		pos = 0;
		if (req_mode == MODE_REMOVE) begin
			if (held_values.size() != 0) begin
				rsp.value = held_values.pop_front();
				rsp.valid = 1'b1;
			end
		end else if (held_values.size() >= STORE_DEPTH) begin
			rsp.dropped = 1'b1;
		end else begin
			while (pos < held_values.size() && held_values[pos] < req_value)
				pos++;
			held_values.insert(pos, req_value);
		end
		rsp.count = COUNT_W'(held_values.size());
		owed_rsps.push_back(rsp);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at response word %0d: %s", words_out, what);
		mismatches++;
	endtask

	task automatic queue_word(input logic req_mode, input logic [VALUE_W-1:0] req_value,
			input logic drain_first);
		store_req_t req;
		req.mode = req_mode;
		req.value = req_value;
		req.wait_drain = drain_first;
		pending_reqs.push_back(req);
	endtask

	// Values come from three classes: a narrow range that makes many duplicates,
	// the extremes and their neighbors, and the full range.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(3))
			0: begin
				v = VALUE_W'($urandom_range(15));
			end
			1: begin
				case ($urandom_range(3))
					0: v = '0;
					1: v = '1;
					2: v = VALUE_W'(1);
					default: v = VALUE_W'(16'hFFFE);
				endcase
			end
			default: begin
				v = VALUE_W'($urandom_range(65535));
			end
		endcase
		return v;
	endfunction

	// Picks a mode with the given chance of an insert, in percent.
	function automatic logic pick_mode(input int insert_pct);
		return ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
	endfunction

	assign hold_active = (hold_left != 0);
	assign send_quiet = (words_in >= QUIET_FROM) && (words_in < QUIET_TO);
	assign take_quiet = (words_out >= QUIET_FROM) && (words_out < QUIET_TO);

	// Driver. Whenever the current word has been accepted or none is offered, it
	// takes a word from the pending queue or idles at random. Valid does
	// not look at stall; a stalled word stays on the port unchanged. Each request
	// word is applied to the bench's store at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				apply_store_word(mode, value);
				words_in <= words_in + 1;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() == 0 ||
						(pending_reqs[0].wait_drain && owed_rsps.size() != 0) ||
						(!hold_active && !send_quiet && $urandom_range(99) < IDLE_PCT)) begin
					req_valid <= 1'b0;
				end else begin
					req_valid <= 1'b1;
					mode <= pending_reqs[0].mode;
					value <= pending_reqs[0].value;
					void'(pending_reqs.pop_front());
				end
			end
		end
	end

	// The long hold-off on the response side is counted here, apart from the
	// monitor, and starts once after enough request words have gone in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_started <= 1'b0;
		end else if (!hold_started && words_in >= HOLD_AFTER_WORDS) begin
			hold_left <= HOLD_CYCLES;
			hold_started <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor. Every response word taken is checked field by field against the
	// oldest response still owed. The stall it drives is random, held high for
	// the whole hold-off and kept low through the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				words_out <= words_out + 1;
				if (owed_rsps.size() == 0) begin
					report_mismatch("response word with none owed");
				end else begin
					if (out_value !== owed_rsps[0].value)
						report_mismatch($sformatf("out_value %h, expected %h",
							out_value, owed_rsps[0].value));
					if (out_valid !== owed_rsps[0].valid)
						report_mismatch($sformatf("out_valid %b, expected %b",
							out_valid, owed_rsps[0].valid));
					if (stored_count !== owed_rsps[0].count)
						report_mismatch($sformatf("stored_count %0d, expected %0d",
							stored_count, owed_rsps[0].count));
					if (dropped !== owed_rsps[0].dropped)
						report_mismatch($sformatf("dropped %b, expected %b",
							dropped, owed_rsps[0].dropped));
					void'(owed_rsps.pop_front());
				end
			end
			rsp_stall <= hold_active ||
				(!take_quiet && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog: a run that stops moving ends here as a failure.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		// Directed words first. A remove on the empty store, then inserts that hit
		// both extremes, duplicates at the bottom and at the top, and the two
		// alternating bit patterns, then enough removes to empty the store and
		// remove once more from the empty store.
		queue_word(MODE_REMOVE, '1, 1'b0);
		queue_word(MODE_INSERT, '1, 1'b0);
		queue_word(MODE_INSERT, '0, 1'b0);
		queue_word(MODE_INSERT, '0, 1'b0);
		queue_word(MODE_INSERT, 16'h8000, 1'b0);
		queue_word(MODE_INSERT, 16'h7FFF, 1'b0);
		queue_word(MODE_INSERT, '1, 1'b0);
		queue_word(MODE_INSERT, 16'h5555, 1'b0);
		queue_word(MODE_INSERT, 16'hAAAA, 1'b0);
		for (int i = 0; i < 9; i++)
			queue_word(MODE_REMOVE, 16'hAAAA, 1'b0);

		// Fill phase: nearly all inserts, so the store reaches its capacity and
		// further inserts are refused. The long response hold-off falls in here.
		for (int i = 0; i < 160; i++)
			queue_word(pick_mode(95), pick_value(), 1'b0);

		// Drain phase: the sender waits for every owed response first, then mostly
		// removes until the store runs empty and removes find nothing.
		for (int i = 0; i < 170; i++)
			queue_word(pick_mode(10), pick_value(), i == 0);

		// Mixed traffic around a moderate fill level.
		for (int i = 0; i < 300; i++)
			queue_word(pick_mode(55), pick_value(), 1'b0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0)
			@(posedge clk);
		// Any stray response word would show up during this wait.
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
